/* rtl/u8d_pkg.sv */
// Package for the UTF-8 stream decoder: field widths, length codes,
// decoder state and result types, and the lead-byte length function.
// No dependencies.
package u8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 31;
    localparam int LEN_W       = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int RESULT_W    = CODE_W + LEN_W + 1;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [LEN_W-1:0]  len_t;

    // Sequence length codes; LEN_BAD marks a byte that cannot start a sequence
    localparam len_t LEN_BAD   = 3'd0;
    localparam len_t LEN_ONE   = 3'd1;
    localparam len_t LEN_TWO   = 3'd2;
    localparam len_t LEN_THREE = 3'd3;
    localparam len_t LEN_FOUR  = 3'd4;
    localparam len_t LEN_FIVE  = 3'd5;
    localparam len_t LEN_SIX   = 3'd6;

    typedef struct packed {
        code_t code_accum;
        len_t  bytes_left;
        len_t  cur_len;
    } dec_state_t;

    typedef struct packed {
        logic  bad_lead;
        len_t  seq_len;
        code_t code_point;
    } dec_result_t;

    // Sequence length from a lead byte: count of leading ones, 0x80..0xBF and 0xFE/0xFF are bad
    function automatic len_t lead_length(input byte_t b);
        len_t len;
        begin
            if (!b[7])
                len = LEN_ONE;
            else if (!b[6])
                len = LEN_BAD;
            else if (!b[5])
                len = LEN_TWO;
            else if (!b[4])
                len = LEN_THREE;
            else if (!b[3])
                len = LEN_FOUR;
            else if (!b[2])
                len = LEN_FIVE;
            else if (!b[1])
                len = LEN_SIX;
            else
                len = LEN_BAD;
            return len;
        end
    endfunction

endpackage

/* rtl/u8d_decode.sv */
// Single-byte decode step of the UTF-8 stream decoder: next state and
// optional result from the current state and one byte. Depends on u8d_pkg.
module u8d_decode (
    input  u8d_pkg::byte_t       in_byte,
    input  u8d_pkg::dec_state_t  state,
    output u8d_pkg::dec_state_t  state_next,
    output u8d_pkg::dec_result_t result,
    output logic                 has_result
);
    import u8d_pkg::*;

    len_t  lead_len;
    len_t  left_dec;
    code_t lead_top;
    code_t payload;
    code_t accum_or;

    assign lead_len = lead_length(in_byte);
    assign left_dec = state.bytes_left - 3'd1;
    assign accum_or = state.code_accum | payload;

    // Place the lead byte's payload bits above the continuation groups
    always_comb
    begin
        case (lead_len)
            LEN_TWO:   lead_top = code_t'({in_byte[4:0], 6'd0});
            LEN_THREE: lead_top = code_t'({in_byte[3:0], 12'd0});
            LEN_FOUR:  lead_top = code_t'({in_byte[2:0], 18'd0});
            LEN_FIVE:  lead_top = code_t'({in_byte[1:0], 24'd0});
            LEN_SIX:   lead_top = code_t'({in_byte[0], 30'd0});
            default:   lead_top = '0;
        endcase
    end

    // Continuation payload: six bits at the group that remains after this byte
    always_comb
    begin
        case (left_dec)
            3'd1:    payload = code_t'({in_byte[5:0], 6'd0});
            3'd2:    payload = code_t'({in_byte[5:0], 12'd0});
            3'd3:    payload = code_t'({in_byte[5:0], 18'd0});
            3'd4:    payload = code_t'({in_byte[5:0], 24'd0});
            default: payload = code_t'(in_byte[5:0]);
        endcase
    end

    always_comb
    begin
        state_next = state;
        result     = '0;
        has_result = 1'b0;
        if (state.bytes_left == '0)
        begin
            if (lead_len == LEN_BAD)
            begin
                // Bad lead: report and keep looking for a lead
                result.bad_lead = 1'b1;
                has_result      = 1'b1;
            end
            else if (lead_len == LEN_ONE)
            begin
                result.code_point = code_t'(in_byte[6:0]);
                result.seq_len    = LEN_ONE;
                has_result        = 1'b1;
            end
            else
            begin
                state_next.code_accum = lead_top;
                state_next.bytes_left = lead_len - 3'd1;
                state_next.cur_len    = lead_len;
            end
        end
        else if (left_dec == '0)
        begin
            result.code_point = accum_or;
            result.seq_len    = state.cur_len;
            has_result        = 1'b1;
            state_next        = '0;
        end
        else
        begin
            state_next.code_accum = accum_or;
            state_next.bytes_left = left_dec;
        end
    end

endmodule

/* rtl/utf8_stream_decoder_unit.sv */
// Top level of the UTF-8 stream decoder: input register, decode step and
// result register with stream handshakes. Depends on u8d_pkg, u8d_decode.
//
// Decodes a UTF-8 byte stream in the original scheme of one to six bytes per
// character. Each slave request carries one byte; a master request is sent
// for every completed character (code point and its length) and for every
// byte that cannot start a sequence (bad_lead set, code point and length
// zero). Continuation bytes are not checked for their 10xxxxxx tag, and
// overlong forms pass as assembled. The block takes one byte per clock
// cycle when the master side is ready. An accepted byte sits in the
// input register and passes through the decode step into the result
// register, from which its result, if any, is offered. The rate is set
// by the decode step, which updates the running accumulator, length and
// byte count together. Back-pressure on the master side stalls the input
// register and then the slave side.
module utf8_stream_decoder_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [u8d_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] in_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [u8d_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [30:0] code_point,
                                                              // [33:31] seq_len,
                                                              // [34] bad_lead, rest zero
);
    import u8d_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    byte_t       in_byte_reg;

    // Decoder state
    dec_state_t  state_reg;
    dec_state_t  state_next;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t out_reg;

    dec_result_t result;
    logic        has_result;
    logic        in_accept;
    logic        fire;

    // Advance the held byte whenever the result register is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    u8d_decode u_decode (
        .in_byte    (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result),
        .has_result (has_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = has_result;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Payload registers: byte loads on acceptance, result on a fire with a result; hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_byte_reg <= s_axis_tdata[BYTE_W-1:0];
        if (fire && has_result)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_reg};

endmodule

/* rtl/u8d_checker.sv */
// Port-level checks for the UTF-8 stream decoder, bound to its top level.
// Depends on u8d_pkg and utf8_stream_decoder_unit.
module u8d_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [u8d_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import u8d_pkg::*;

    logic  bad;
    len_t  len;
    code_t cp;

    assign bad     = m_axis_tdata[CODE_W+LEN_W];
    assign len     = m_axis_tdata[CODE_W+LEN_W-1:CODE_W];
    assign cp      = m_axis_tdata[CODE_W-1:0];

    // Error result carries no code point and no length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && bad |-> cp == '0 && len == LEN_BAD)
        else $error("error result with nonzero payload");

    // Good result has a length of one to six bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !bad |-> len == LEN_ONE || len == LEN_TWO || len == LEN_THREE
            || len == LEN_FOUR || len == LEN_FIVE || len == LEN_SIX)
        else $error("good result with bad length");

    // Code point fits the bits its length can carry (checked for one- and two-byte lengths)
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && len == LEN_ONE |-> cp[CODE_W-1:7] == '0)
        else $error("one-byte code point out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && len == LEN_TWO |-> cp[CODE_W-1:11] == '0)
        else $error("two-byte code point out of range");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_unit u8d_checker u_u8d_checker (.*);
